@@ hw/rtl/lec_pkg.sv @@
// Shared types and constants of the line editor.
// No dependencies; every other file of the block but lec_ram uses it.
`default_nettype none

package lec_pkg;

  localparam int LINE_CAPACITY_DEF = 64;
  localparam int MAX_RESULTS       = 64;

  localparam int KEY_W   = 8;
  localparam int ACT_W   = 2;
  localparam int CNT_W   = 7;
  localparam int CFG_IDX_W = 3;

  // Result actions.
  localparam logic [ACT_W-1:0] ACT_ECHO   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RUBOUT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BELL   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_END    = 2'd3;

  // Word erase phases.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SPACES = 2'd1;
  localparam logic [1:0] PH_WORD   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EOF_CODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_CODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WERASE_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL_CODE   = 3'd4;

  // Register reset values.
  localparam logic [CNT_W-1:0] RST_LINE_LIMIT  = 7'd40;
  localparam logic [KEY_W-1:0] RST_EOF_CODE    = 8'd4;
  localparam logic [KEY_W-1:0] RST_ERASE_CODE  = 8'd127;
  localparam logic [KEY_W-1:0] RST_WERASE_CODE = 8'd23;
  localparam logic [KEY_W-1:0] RST_KILL_CODE   = 8'd21;

  localparam logic [KEY_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [KEY_W-1:0] PRINT_LO   = 8'h20;
  localparam logic [KEY_W-1:0] PRINT_HI   = 8'h7E;

  typedef struct packed {
    logic [CNT_W-1:0] line_limit;       // already saturated to the smaller of the line capacity and MAX_RESULTS
    logic [KEY_W-1:0] eof_code;
    logic [KEY_W-1:0] erase_code;
    logic [KEY_W-1:0] word_erase_code;
    logic [KEY_W-1:0] kill_code;
  } lec_cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/lec_if.sv @@
// Handshake channels of the line editor: key words in, result words out.
// Depends on lec_pkg.
`default_nettype none

interface lec_in_if;
  logic                      valid;
  logic                      ready;
  logic [lec_pkg::KEY_W-1:0] key_byte;

  modport source (output valid, output key_byte, input ready);
  modport sink   (input valid, input key_byte, output ready);
endinterface

interface lec_out_if;
  logic                      valid;
  logic                      ready;
  logic [lec_pkg::ACT_W-1:0] action;
  logic [lec_pkg::KEY_W-1:0] echo_char;
  logic [lec_pkg::CNT_W-1:0] line_length;
  logic                      last;

  modport source (output valid, output action, output echo_char, output line_length,
                  output last, input ready);
  modport sink   (input valid, input action, input echo_char, input line_length,
                  input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lec_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lec_cfg.sv @@
// Configuration register file of the line editor; saturates the line limit.
// Depends on lec_pkg.
`default_nettype none

module lec_cfg #(
  parameter int LINE_CAPACITY = lec_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [lec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lec_pkg::KEY_W-1:0]     cfg_wdata,
  output lec_pkg::lec_cfg_t                  cfg
);
  import lec_pkg::*;

  localparam int EFF_CAP = (LINE_CAPACITY < MAX_RESULTS) ? LINE_CAPACITY : MAX_RESULTS;
  localparam logic [CNT_W-1:0] EFF_CAP_V = CNT_W'(EFF_CAP);

  logic [CNT_W-1:0] limit_r;
  logic [KEY_W-1:0] eof_r, erase_r, werase_r, kill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= RST_LINE_LIMIT;
      eof_r    <= RST_EOF_CODE;
      erase_r  <= RST_ERASE_CODE;
      werase_r <= RST_WERASE_CODE;
      kill_r   <= RST_KILL_CODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_LIMIT:  limit_r  <= cfg_wdata[CNT_W-1:0];
        CFG_EOF_CODE:    eof_r    <= cfg_wdata;
        CFG_ERASE_CODE:  erase_r  <= cfg_wdata;
        CFG_WERASE_CODE: werase_r <= cfg_wdata;
        CFG_KILL_CODE:   kill_r   <= cfg_wdata;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  always_comb begin
    cfg.line_limit      = (limit_r > EFF_CAP_V) ? EFF_CAP_V : limit_r;
    cfg.eof_code        = eof_r;
    cfg.erase_code      = erase_r;
    cfg.word_erase_code = werase_r;
    cfg.kill_code       = kill_r;
  end

endmodule

`default_nettype wire

@@ hw/rtl/lec_ctrl.sv @@
// Sequencer of the line editor: decodes a key word, reads and writes the line
// store RAM, and drives the result register. Depends on lec_pkg.
`default_nettype none

module lec_ctrl #(
  parameter int LINE_CAPACITY = lec_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lec_pkg::lec_cfg_t                 cfg,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [lec_pkg::KEY_W-1:0]         in_key,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [lec_pkg::ACT_W-1:0]         out_action,
  output logic      [lec_pkg::KEY_W-1:0]         out_char,
  output logic      [lec_pkg::CNT_W-1:0]         out_len,
  output logic                                   out_last,
  output logic                                   ram_we,
  output logic      [$clog2(LINE_CAPACITY)-1:0]  ram_waddr,
  output logic      [lec_pkg::KEY_W-1:0]         ram_wdata,
  output logic                                   ram_re,
  output logic      [$clog2(LINE_CAPACITY)-1:0]  ram_raddr,
  input  wire logic [lec_pkg::KEY_W-1:0]         ram_rdata
);
  import lec_pkg::*;

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam int EFF_CAP = (LINE_CAPACITY < MAX_RESULTS) ? LINE_CAPACITY : MAX_RESULTS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_KILL = 3'd2;
  localparam logic [2:0] S_WCHK = 3'd3;
  localparam logic [2:0] S_WFIN = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             pend_r, pend_nxt;

  logic             out_valid_r;
  logic [ACT_W-1:0] out_act_r;
  logic [KEY_W-1:0] out_char_r;
  logic [CNT_W-1:0] out_len_r;
  logic             out_last_r;

  logic             out_free;
  logic             emit;
  logic [ACT_W-1:0] e_act;
  logic [KEY_W-1:0] e_char;
  logic [CNT_W-1:0] e_len;
  logic             e_last;
  logic             rub;
  logic [CNT_W-1:0] lim;

  assign lim      = cfg.line_limit;
  assign out_free = !out_valid_r || out_ready;
  // In the word erase scan: does the character just read go too?
  assign rub      = (phase_r == PH_SPACES) || (ram_rdata != SPACE_CHAR);

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    emit      = 1'b0;
    e_act     = ACT_BELL;
    e_char    = '0;
    e_len     = cnt_r;
    e_last    = 1'b1;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = AW'(cnt_r - CNT_W'(1));
    in_ready  = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt   = in_key;
          cnt_nxt   = (cnt_r > lim) ? lim : cnt_r;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        priority if (key_r == cfg.eof_code) begin
          if (out_free) begin
            emit      = 1'b1;
            e_act     = (cnt_r == '0) ? ACT_END : ACT_BELL;
            state_nxt = S_IDLE;
          end
        end else if (key_r == cfg.erase_code) begin
          if (cnt_r == '0) begin
            state_nxt = S_IDLE;
          end else if (out_free) begin
            emit      = 1'b1;
            e_act     = ACT_RUBOUT;
            e_len     = cnt_r - CNT_W'(1);
            cnt_nxt   = cnt_r - CNT_W'(1);
            state_nxt = S_IDLE;
          end
        end else if (key_r == cfg.word_erase_code) begin
          if (cnt_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            phase_nxt = PH_SPACES;
            pend_nxt  = 1'b0;
            state_nxt = S_WCHK;
          end
        end else if (key_r == cfg.kill_code) begin
          state_nxt = (cnt_r == '0) ? S_IDLE : S_KILL;
        end else if (key_r >= PRINT_LO && key_r <= PRINT_HI) begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
            if (cnt_r < lim) begin
              ram_we  = 1'b1;
              e_act   = ACT_ECHO;
              e_char  = key_r;
              e_len   = cnt_r + CNT_W'(1);
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
        end else begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_KILL: begin
        if (out_free) begin
          emit    = 1'b1;
          e_act   = ACT_RUBOUT;
          e_len   = cnt_r - CNT_W'(1);
          e_last  = (cnt_r == CNT_W'(1));
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_WCHK: begin
        // The pending rubout learns its last flag from the character read now.
        if (!pend_r || out_free) begin
          if (pend_r) begin
            emit   = 1'b1;
            e_act  = ACT_RUBOUT;
            e_last = !rub;
          end
          if (rub) begin
            cnt_nxt  = cnt_r - CNT_W'(1);
            pend_nxt = 1'b1;
            if (ram_rdata != SPACE_CHAR) begin
              phase_nxt = PH_WORD;
            end
            if (cnt_r == CNT_W'(1)) begin
              state_nxt = S_WFIN;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = AW'(cnt_r - CNT_W'(2));
            end
          end else begin
            pend_nxt  = 1'b0;
            phase_nxt = PH_IDLE;
            state_nxt = S_IDLE;
          end
        end
      end
      S_WFIN: begin
        if (out_free) begin
          emit      = 1'b1;
          e_act     = ACT_RUBOUT;
          pend_nxt  = 1'b0;
          phase_nxt = PH_IDLE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign ram_waddr = AW'(cnt_r);
  assign ram_wdata = key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      phase_r     <= PH_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (emit) begin
      out_act_r  <= e_act;
      out_char_r <= e_char;
      out_len_r  <= e_len;
      out_last_r <= e_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = out_act_r;
  assign out_char   = out_char_r;
  assign out_len    = out_len_r;
  assign out_last   = out_last_r;

  // The count never exceeds the capacity of the line store.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(EFF_CAP))
    else $error("line count above capacity");

  // Echo words carry a printable byte and a non-empty line.
  a_echo_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_act_r == ACT_ECHO) |->
      (out_char_r >= PRINT_LO && out_char_r <= PRINT_HI && out_len_r != '0))
    else $error("bad echo word");

  // Every word other than echo carries a zero character.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_act_r != ACT_ECHO) |-> (out_char_r == '0))
    else $error("non-echo word with character");

  // A rubout that is not the last one keeps the sequencer busy.
  a_rub_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && e_act == ACT_RUBOUT && !e_last) |=> (state_r != S_IDLE))
    else $error("rubout chain ended early");

  // No new key is taken while a word erase still holds a rubout back.
  a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_WCHK || state_r == S_WFIN))
    else $error("pending rubout outside word erase");

endmodule

`default_nettype wire

@@ hw/rtl/line_editor_echo_control.sv @@
// Top level of the canonical line editor with echo control.
// Depends on lec_pkg, lec_if, lec_ram, lec_cfg and lec_ctrl.
//
//   channel  | dir | words                                   | accepted when
//   ---------+-----+-----------------------------------------+------------------------
//   in_ch    | in  | key_byte                                | in_ch.valid & ready
//   out_ch   | out | action, echo_char, line_length, last    | out_ch.valid & ready
//   cfg_*    | in  | cfg_index, cfg_wdata                    | cfg_we
//
// Sequence: a key word is latched in S_IDLE and decoded in S_DEC, which completes a
// single-result key (erase included). Kill then emits one rubout a cycle from S_KILL
// and word erase reads the line store RAM one character a cycle in S_WCHK, both while
// results are taken (registered read data, prefetching the next character while the
// current rubout waits for its last flag); word erase sends its final rubout from
// S_WFIN. Reset (rst_n low, synchronous) empties the line and restores the default
// codes and limit; the line store itself is not cleared, since only entries below the
// count are ever read. A stalled result channel holds the sequencer in place.
`default_nettype none

module line_editor_echo_control #(
  parameter int LINE_CAPACITY = lec_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  lec_in_if.sink                             in_ch,
  lec_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [lec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lec_pkg::KEY_W-1:0]     cfg_wdata
);
  import lec_pkg::*;

  localparam int AW = $clog2(LINE_CAPACITY);

  lec_cfg_t         cfg;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  // Registers: limit is saturated to the smaller of the line capacity and MAX_RESULTS before use.
  lec_cfg #(.LINE_CAPACITY(LINE_CAPACITY)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Line store: written on echo, read back during word erase. Writes and reads
  // happen in different items, so no forwarding path is needed.
  lec_ram #(.WIDTH(KEY_W), .DEPTH(LINE_CAPACITY)) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer and result register.
  lec_ctrl #(.LINE_CAPACITY(LINE_CAPACITY)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_key     (in_ch.key_byte),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_action (out_ch.action),
    .out_char   (out_ch.echo_char),
    .out_len    (out_ch.line_length),
    .out_last   (out_ch.last),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

endmodule

`default_nettype wire
